FILE: design/lph_pkg.sv
package lph_pkg;

  localparam int SLOTS = 32;
  localparam int SLOT_W = $clog2(SLOTS);
  localparam int CNT_W = $clog2(SLOTS + 1);
  localparam int KEY_W = 64;
  localparam int VAL_W = 32;

  localparam logic [2:0] ACT_INSERT = 3'd0;
  localparam logic [2:0] ACT_UPDATE = 3'd1;
  localparam logic [2:0] ACT_SET    = 3'd2;
  localparam logic [2:0] ACT_GET    = 3'd3;
  localparam logic [2:0] ACT_DELETE = 3'd4;

  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_NOTFOUND = 2'd1;
  localparam logic [1:0] ST_EXISTS   = 2'd2;
  localparam logic [1:0] ST_FULL     = 2'd3;

  localparam logic [6:0] THRESH_RESET = 7'd60;

  typedef struct packed {
    logic [2:0]  action;
    logic [63:0] key_bytes;
    logic [3:0]  key_length;
    logic [31:0] value_in;
  } in_item_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [31:0] value_out;
    logic [5:0]  element_total;
    logic        load_high;
  } out_item_t;

  // datapath commands
  typedef struct packed {
    logic load;       // capture item, start hash
    logic hash_step;  // one key byte into the hash
    logic probe_init; // cursor to home slot
    logic probe_next; // advance cursor
    logic do_insert;
    logic do_update;
    logic del_init;   // clear hit slot, start shift
    logic shift_move; // move cursor entry into hole
    logic shift_next;
    logic cnt_inc;
    logic cnt_dec;
  } lph_cmd_t;

  typedef struct packed {
    logic hash_done;
    logic slot_used;  // current cursor slot occupied
    logic slot_match;
    logic probe_last; // cursor is on the last slot of the probe
    logic shift_wrap; // shift cursor back at deleted slot
    logic shift_fit;  // entry may move into the hole
    logic [2:0] action;
  } lph_stat_t;

endpackage

FILE: design/linear_probe_hash_table.sv
// open-addressing hash table of 32 slots with times-33 byte hashing (djb2 step,
// but seeded with zero), linear probing and backward-shift delete; one
// transaction at a time: the item is accepted and its key hashed one byte at a
// time, slots are probed in turn (up to 32), and for delete the shift walks the
// following slots (up to 32, the last one ending the walk), then the result is
// held until taken
module linear_probe_hash_table (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  lph_pkg::in_item_t  in_data,
  output logic               out_valid,
  input  logic               out_stall,
  output lph_pkg::out_item_t out_data,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [0:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready
);
  lph_pkg::lph_cmd_t  cmd;
  lph_pkg::lph_stat_t stat;
  logic [31:0] found_value;
  logic [lph_pkg::CNT_W-1:0] count;
  logic [6:0] thresh_r;

  // threshold register at address zero
  always_ff @(posedge clk) begin
    if (!rst_n) thresh_r <= lph_pkg::THRESH_RESET;
    else if (psel && penable && pwrite && paddr == 1'b0) thresh_r <= pwdata[6:0];
  end
  assign pready = 1'b1;
  assign prdata = (paddr == 1'b0) ? {25'd0, thresh_r} : 32'd0;

  lph_ctrl u_ctrl (
    .clk, .rst_n, .in_valid, .in_stall, .out_valid, .out_stall,
    .stat, .found_value, .count, .thresh(thresh_r), .cmd, .out_item(out_data)
  );

  lph_datapath u_dp (
    .clk, .rst_n, .in_item(in_data), .cmd, .stat, .found_value, .count
  );

  // no new transaction while a result waits
  a_no_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> in_stall) else $error("accept while result pending");
  // count never exceeds slot total
  a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
    count <= lph_pkg::CNT_W'(lph_pkg::SLOTS)) else $error("count overflow");
  // accepted transaction moves controller out of idle
  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |=> in_stall) else $error("idle after accept");
endmodule

FILE: design/lph_datapath.sv
module lph_datapath (
  input  logic              clk,
  input  logic              rst_n,
  input  lph_pkg::in_item_t in_item,
  input  lph_pkg::lph_cmd_t cmd,
  output lph_pkg::lph_stat_t stat,
  output logic [31:0]       found_value,
  output logic [lph_pkg::CNT_W-1:0] count
);
  logic [lph_pkg::SLOTS-1:0] used_r;
  logic [63:0] hash_m [lph_pkg::SLOTS];
  logic [63:0] key_m  [lph_pkg::SLOTS];
  logic [3:0]  len_m  [lph_pkg::SLOTS];
  logic [31:0] val_m  [lph_pkg::SLOTS];
  logic [lph_pkg::SLOT_W-1:0] dist_m [lph_pkg::SLOTS];

  logic [2:0]  act_r;
  logic [63:0] key_r, h_r, kshift_r;
  logic [3:0]  len_r, bi_r;
  logic [31:0] data_r;
  logic [lph_pkg::SLOT_W-1:0] cur_r, cur_nxt, d_r, hole_r, del_r;
  logic [lph_pkg::SLOT_W:0]   gap_r;
  logic [lph_pkg::CNT_W-1:0]  cnt_r;
  logic [3:0]  len_c;
  logic [63:0] mask_c;
  logic [lph_pkg::SLOT_W-1:0] home_c;
  // registered read of the entry under the cursor
  logic [63:0] rd_hash_r, rd_key_r;
  logic [3:0]  rd_len_r;
  logic [31:0] rd_val_r;
  logic [lph_pkg::SLOT_W-1:0] rd_dist_r;

  always_comb begin
    len_c = (in_item.key_length > 4'd8) ? 4'd8 : in_item.key_length;
    mask_c = '0;
    for (int i = 0; i < 8; i++) begin
      if (4'(i) < len_c) mask_c[i*8 +: 8] = 8'hff;
    end
  end

  assign home_c = h_r[lph_pkg::SLOT_W-1:0];

  always_comb begin
    cur_nxt = cur_r;
    if (cmd.probe_init) cur_nxt = home_c;
    else if (cmd.probe_next || cmd.del_init || cmd.shift_move || cmd.shift_next)
      cur_nxt = cur_r + 1'b1;
  end

  always_ff @(posedge clk) begin
    cur_r     <= cur_nxt;
    rd_hash_r <= hash_m[cur_nxt];
    rd_key_r  <= key_m[cur_nxt];
    rd_len_r  <= len_m[cur_nxt];
    rd_val_r  <= val_m[cur_nxt];
    rd_dist_r <= dist_m[cur_nxt];
    if (cmd.load) begin
      act_r    <= in_item.action;
      key_r    <= in_item.key_bytes & mask_c;
      kshift_r <= in_item.key_bytes & mask_c;
      len_r    <= len_c;
      data_r   <= in_item.value_in;
      h_r      <= '0;
      bi_r     <= '0;
    end
    if (cmd.hash_step) begin
      h_r      <= (h_r << 5) + h_r + {56'd0, kshift_r[7:0]};
      kshift_r <= kshift_r >> 8;
      bi_r     <= bi_r + 4'd1;
    end
    if (cmd.probe_init) begin
      d_r <= '0;
    end
    if (cmd.probe_next) begin
      d_r <= d_r + 1'b1;
    end
    if (cmd.do_insert) begin
      hash_m[cur_r] <= h_r;
      key_m[cur_r]  <= key_r;
      len_m[cur_r]  <= len_r;
      val_m[cur_r]  <= data_r;
      dist_m[cur_r] <= d_r;
    end
    if (cmd.do_update) val_m[cur_r] <= data_r;
    if (cmd.del_init) begin
      hole_r <= cur_r;
      del_r  <= cur_r;
      gap_r  <= (lph_pkg::SLOT_W+1)'(1);
    end
    if (cmd.shift_move) begin
      hash_m[hole_r] <= rd_hash_r;
      key_m[hole_r]  <= rd_key_r;
      len_m[hole_r]  <= rd_len_r;
      val_m[hole_r]  <= rd_val_r;
      dist_m[hole_r] <= lph_pkg::SLOT_W'({1'b0, rd_dist_r} - gap_r);
      hole_r <= cur_r;
      gap_r  <= (lph_pkg::SLOT_W+1)'(1);
    end else if (cmd.shift_next) begin
      gap_r <= gap_r + 1'b1;
    end
  end

  // occupancy flags and count are control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      used_r <= '0;
      cnt_r  <= '0;
    end else begin
      if (cmd.do_insert) used_r[cur_r] <= 1'b1;
      if (cmd.del_init) used_r[cur_r] <= 1'b0;
      if (cmd.shift_move) begin
        used_r[hole_r] <= 1'b1;
        used_r[cur_r]  <= 1'b0;
      end
      if (cmd.cnt_inc) cnt_r <= cnt_r + 1'b1;
      else if (cmd.cnt_dec && cnt_r != '0) cnt_r <= cnt_r - 1'b1;
    end
  end

  assign stat.hash_done  = (bi_r == len_r);
  assign stat.slot_used  = used_r[cur_r];
  assign stat.slot_match = (rd_hash_r == h_r) && (rd_len_r == len_r)
                           && (rd_key_r == key_r);
  assign stat.probe_last = (d_r == lph_pkg::SLOT_W'(lph_pkg::SLOTS - 1));
  assign stat.shift_wrap = (cur_r == del_r);
  assign stat.shift_fit  = ({1'b0, rd_dist_r} >= gap_r);
  assign stat.action     = act_r;
  assign found_value     = rd_val_r;
  assign count           = cnt_r;
endmodule

FILE: design/lph_ctrl.sv
module lph_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  output logic               out_valid,
  input  logic               out_stall,
  input  lph_pkg::lph_stat_t stat,
  input  logic [31:0]        found_value,
  input  logic [lph_pkg::CNT_W-1:0] count,
  input  logic [6:0]         thresh,
  output lph_pkg::lph_cmd_t  cmd,
  output lph_pkg::out_item_t out_item
);
  typedef enum logic [2:0] {S_IDLE, S_HASH, S_PROBE, S_SHIFT, S_FIN, S_OUT} state_t;
  state_t state_r, state_nxt;
  logic [1:0]  st_r, st_nxt;
  logic [31:0] val_r, val_nxt;
  logic        high_r, high_nxt;
  logic [12:0] load_c;

  assign load_c = (13'(count) * 13'd100) >> lph_pkg::SLOT_W;

  always_comb begin
    cmd = '0;
    state_nxt = state_r;
    st_nxt = st_r;
    val_nxt = val_r;
    high_nxt = high_r;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load = 1'b1;
          st_nxt = lph_pkg::ST_OK;
          val_nxt = '0;
          high_nxt = (load_c >= 13'(thresh));
          state_nxt = S_HASH;
        end
      end
      S_HASH: begin
        if (stat.hash_done) begin
          cmd.probe_init = 1'b1;
          state_nxt = (stat.action > lph_pkg::ACT_DELETE) ? S_OUT : S_PROBE;
        end else begin
          cmd.hash_step = 1'b1;
        end
      end
      S_PROBE: begin
        if (!stat.slot_used || stat.slot_match) begin
          state_nxt = S_OUT;
          if (stat.action == lph_pkg::ACT_INSERT ||
              (stat.action == lph_pkg::ACT_SET && !stat.slot_used)) begin
            if (stat.slot_used) st_nxt = lph_pkg::ST_EXISTS;
            else begin
              cmd.do_insert = 1'b1;
              cmd.cnt_inc = 1'b1;
            end
          end else if (!stat.slot_used) begin
            st_nxt = lph_pkg::ST_NOTFOUND;
          end else begin
            val_nxt = found_value;
            if (stat.action == lph_pkg::ACT_UPDATE || stat.action == lph_pkg::ACT_SET)
              cmd.do_update = 1'b1;
            else if (stat.action == lph_pkg::ACT_DELETE) begin
              cmd.del_init = 1'b1;
              cmd.cnt_dec = 1'b1;
              state_nxt = S_SHIFT;
            end
          end
        end else if (stat.probe_last) begin
          state_nxt = S_OUT;
          if (stat.action == lph_pkg::ACT_INSERT || stat.action == lph_pkg::ACT_SET)
            st_nxt = lph_pkg::ST_FULL;
          else st_nxt = lph_pkg::ST_NOTFOUND;
        end else begin
          cmd.probe_next = 1'b1;
        end
      end
      S_SHIFT: begin
        if (stat.shift_wrap || !stat.slot_used) state_nxt = S_OUT;
        else if (stat.shift_fit) cmd.shift_move = 1'b1;
        else cmd.shift_next = 1'b1;
      end
      S_FIN: state_nxt = S_OUT;
      S_OUT: if (!out_stall) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
    st_r <= st_nxt;
    val_r <= val_nxt;
    high_r <= high_nxt;
  end

  assign in_stall = (state_r != S_IDLE);
  assign out_valid = (state_r == S_OUT);
  assign out_item.status = st_r;
  assign out_item.value_out = val_r;
  assign out_item.element_total = 6'(count);
  assign out_item.load_high = high_r;
endmodule
